// ===== rtl/bdpc_pkg.sv =====
package bdpc_pkg;

  // Width of the timestamp field on the input channel.
  localparam int NOW_WIDTH = 32;
  // Width of each configuration register.
  localparam int CFG_WIDTH = 16;
  // Default width of the internal time arithmetic.
  localparam int TIME_WIDTH_DEF = 32;

  localparam logic [CFG_WIDTH-1:0] DEBOUNCE_RESET   = 16'd15;
  localparam logic [CFG_WIDTH-1:0] SHORT_MAX_RESET  = 16'd1000;
  localparam logic [CFG_WIDTH-1:0] LONG_PRESS_RESET = 16'd2000;

  // Configuration register indexes (byte address is four times the index).
  typedef enum logic [1:0] {
    REG_DEBOUNCE   = 2'd0,
    REG_SHORT_MAX  = 2'd1,
    REG_LONG_PRESS = 2'd2
  } reg_idx_t;

  typedef struct packed {
    logic                 pin_level;
    logic [NOW_WIDTH-1:0] now_ms;
  } in_item_t;

  typedef struct packed {
    logic stable_out;
    logic press_event;
    logic release_event;
    logic short_event;
    logic long_event;
  } out_item_t;

  typedef struct packed {
    logic [CFG_WIDTH-1:0] debounce_ms;
    logic [CFG_WIDTH-1:0] short_max_ms;
    logic [CFG_WIDTH-1:0] long_press_ms;
  } cfg_t;

endpackage

// ===== rtl/bdpc_core.sv =====
module bdpc_core import bdpc_pkg::*; #(
  parameter int TIME_WIDTH = TIME_WIDTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      step,
  input  in_item_t  item,
  input  cfg_t      cfg,
  output out_item_t result
);

  logic                  raw_seen_r,     raw_seen_nxt;
  logic                  stable_r,       stable_nxt;
  logic                  settling_r,     settling_nxt;
  logic                  long_armed_r,   long_armed_nxt;
  logic [TIME_WIDTH-1:0] settle_start_r, settle_start_nxt;
  logic [TIME_WIDTH-1:0] press_start_r,  press_start_nxt;

  logic                  now_pin;
  logic [TIME_WIDTH-1:0] now_t;
  logic                  raw_chg;
  logic                  settling_a;
  logic [TIME_WIDTH-1:0] settle_el;
  logic                  settle_done;
  logic                  edge_seen;
  logic                  press_ev;
  logic                  release_ev;
  logic                  short_ev;
  logic                  long_ev;
  logic                  armed_a;
  logic [TIME_WIDTH-1:0] held_el;
  logic [TIME_WIDTH-1:0] held_el_nxt;

  assign now_pin = item.pin_level;
  assign now_t   = TIME_WIDTH'(item.now_ms);

  always_comb begin
    // A raw change restarts the settle window at this poll's time.
    raw_chg          = (now_pin != raw_seen_r);
    raw_seen_nxt     = now_pin;
    settling_a       = raw_chg | settling_r;
    settle_start_nxt = raw_chg ? now_t : settle_start_r;
    settle_el        = now_t - settle_start_nxt;
    settle_done      = settling_a && (settle_el >= TIME_WIDTH'(cfg.debounce_ms));
    stable_nxt       = settle_done ? now_pin : stable_r;
    settling_nxt     = settling_a && !settle_done;

    edge_seen  = (stable_nxt != stable_r);
    press_ev   = edge_seen && !stable_nxt;
    release_ev = edge_seen && stable_nxt;

    held_el  = now_t - press_start_r;
    short_ev = release_ev && (held_el <= TIME_WIDTH'(cfg.short_max_ms));

    press_start_nxt = press_ev ? now_t : press_start_r;
    armed_a         = press_ev | (long_armed_r & !release_ev);
    held_el_nxt     = now_t - press_start_nxt;
    long_ev         = armed_a && (held_el_nxt >= TIME_WIDTH'(cfg.long_press_ms));
    long_armed_nxt  = armed_a && !long_ev;

    result.stable_out    = stable_nxt;
    result.press_event   = press_ev;
    result.release_event = release_ev;
    result.short_event   = short_ev;
    result.long_event    = long_ev;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      raw_seen_r     <= 1'b1;
      stable_r       <= 1'b1;
      settling_r     <= 1'b0;
      long_armed_r   <= 1'b0;
      settle_start_r <= '0;
      press_start_r  <= '0;
    end else if (step) begin
      raw_seen_r     <= raw_seen_nxt;
      stable_r       <= stable_nxt;
      settling_r     <= settling_nxt;
      long_armed_r   <= long_armed_nxt;
      settle_start_r <= settle_start_nxt;
      press_start_r  <= press_start_nxt;
    end
  end

endmodule

// ===== rtl/button_debounce_press_classifier.sv =====
// Debounces an active-low push button and classifies its presses. Each input
// item is one poll: the raw pin level (0 pressed) and a millisecond timestamp.
// A raw change restarts a settle window; once the raw level has held for
// debounce_ms the debounced level follows it. Each poll yields exactly one
// result item with the debounced level and four event flags: press, release,
// short press (released with hold time at most short_max_ms) and long press
// (fires once when the hold time reaches long_press_ms). All time differences
// wrap modulo 2^TIME_WIDTH. After reset every level reads as released, so
// start-up produces no events. Throughput is one item per clock cycle while
// the result channel is not stalled. The item is captured in an input
// register, and the classifier computes the result and its next state
// combinationally from it into the result register and its own state.
// Registers sit on the APB port at byte addresses 0 (debounce_ms),
// 4 (short_max_ms) and 8 (long_press_ms), 16 bits each; the user must write
// them only while the block is idle, which the block itself does not enforce.
module button_debounce_press_classifier import bdpc_pkg::*; #(
  parameter int TIME_WIDTH = TIME_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // Input channel.
  input  logic        in_valid,
  output logic        in_stall,
  input  in_item_t    in_item,
  // Result channel.
  output logic        out_valid,
  input  logic        out_stall,
  output out_item_t   out_item,
  // Configuration port.
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  cfg_t      cfg_r;
  logic      in_vld_r;
  in_item_t  in_item_r;
  logic      out_vld_r;
  out_item_t out_item_r;
  out_item_t result;
  logic      advance;
  logic      cfg_wr;
  reg_idx_t  reg_idx;

  // Register block. The write is taken in the access phase.
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign reg_idx = reg_idx_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.debounce_ms   <= DEBOUNCE_RESET;
      cfg_r.short_max_ms  <= SHORT_MAX_RESET;
      cfg_r.long_press_ms <= LONG_PRESS_RESET;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_DEBOUNCE:   cfg_r.debounce_ms   <= pwdata[CFG_WIDTH-1:0];
        REG_SHORT_MAX:  cfg_r.short_max_ms  <= pwdata[CFG_WIDTH-1:0];
        REG_LONG_PRESS: cfg_r.long_press_ms <= pwdata[CFG_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_DEBOUNCE:   prdata = 32'(cfg_r.debounce_ms);
      REG_SHORT_MAX:  prdata = 32'(cfg_r.short_max_ms);
      REG_LONG_PRESS: prdata = 32'(cfg_r.long_press_ms);
      default:        prdata = '0;
    endcase
  end

  // The held item moves on whenever the result register is empty or its
  // item is being taken in this cycle; the input register refills at once.
  assign advance  = in_vld_r && (!out_vld_r || !out_stall);
  assign in_stall = in_vld_r && !advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (!in_stall) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_item_r <= in_item;
    end
  end

  // The classifier updates its state exactly once per item, as the item
  // moves into the result register.
  bdpc_core #(
    .TIME_WIDTH (TIME_WIDTH)
  ) u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (advance),
    .item   (in_item_r),
    .cfg    (cfg_r),
    .result (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (advance) begin
      out_vld_r <= 1'b1;
    end else if (!out_stall) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_item_r <= result;
    end
  end

  assign out_valid = out_vld_r;
  assign out_item  = out_item_r;

endmodule

// ===== rtl/bdpc_chk.sv =====
module bdpc_chk import bdpc_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      out_valid,
  input logic      out_stall,
  input out_item_t out_item
);

  // A result waiting on a stall keeps its contents.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_item))
    else $error("result item changed while stalled");

  // A press edge leaves the debounced level pressed, a release edge released.
  a_press_level: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.press_event |-> !out_item.stable_out &&
      !out_item.release_event && !out_item.short_event)
    else $error("press event with inconsistent level or flags");

  a_release_level: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.release_event |-> out_item.stable_out &&
      !out_item.long_event)
    else $error("release event with inconsistent level or flags");

  // A short press is only ever reported on a release.
  a_short_on_release: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.short_event |-> out_item.release_event)
    else $error("short press without release");

  // Reset empties the result register.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind button_debounce_press_classifier bdpc_chk u_bdpc_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_item  (out_item)
);
